// File: hdl/two_key_record_sorter_macros.svh
`ifndef TWO_KEY_RECORD_SORTER_MACROS_SVH
`define TWO_KEY_RECORD_SORTER_MACROS_SVH
// Assertion helpers, sampled on the rising clock, quiet in reset.
`define TKRS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define TKRS_ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) else $error(msg);
`endif

// File: hdl/tkrs_pkg.sv
`timescale 1ns / 1ps
package tkrs_pkg;
  localparam int unsigned MaxRecords = 32;
  localparam int unsigned NameBytes  = 40;
  localparam int unsigned NameWords  = 5;
  localparam int unsigned IdW        = 24;
  localparam int unsigned ProgW      = 14;
  localparam int unsigned ScoreW     = 32;
  localparam int unsigned NameW      = 64 * NameWords;
  localparam int unsigned RecW       = IdW + NameW + ProgW + ScoreW;
  localparam int unsigned InDataW    = 392;

  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic [ProgW-1:0]  prog;
    logic [NameW-1:0]  name;
    logic [IdW-1:0]    id;
  } rec_t;

  // Key of one record: name (first byte highest), then id.
  typedef struct packed {
    logic [NameW-1:0] name;
    logic [IdW-1:0]   id;
  } key_t;

  // Clear name bytes at or beyond the configured name length.
  function automatic logic [NameW-1:0] name_mask(input logic [NameW-1:0] n,
                                                  input int unsigned nb);
    logic [NameW-1:0] r;
    r = n;
    for (int k = 0; k < NameW / 8; k++) begin
      if (k >= nb) r[NameW-1-8*k -: 8] = 8'd0;
    end
    return r;
  endfunction

  // strcmp view: bytes after the first zero byte count as zero. Bytes are
  // equal up to the shared terminator, so zeroing tails keeps order exact.
  function automatic logic [NameW-1:0] name_canon(input logic [NameW-1:0] n);
    logic [NameW-1:0] r;
    logic             z;
    r = n;
    z = 1'b0;
    for (int k = 0; k < NameW / 8; k++) begin
      if (z) r[NameW-1-8*k -: 8] = 8'd0;
      if (n[NameW-1-8*k -: 8] == 8'd0) z = 1'b1;
    end
    return r;
  endfunction
endpackage

// File: hdl/two_key_record_sorter.sv
`timescale 1ns / 1ps
// Batch sorter. Records stream in one per transaction into a record memory
// and a key memory. Each record is placed by insertion: the key memory is
// walked from the top of the sorted list downwards, one entry per cycle,
// comparing and shifting each larger entry up by one; this pace is set by
// the single key comparator and the one-read, one-write key memory port.
// A record that arrives while the memory is full is dropped and flags
// overflow. The sorted order is kept as record indices. After the last
// transaction, results are read out through a two-deep output register;
// a new read is issued before earlier ones finish only while that register
// can hold every read in flight. No clearing pass runs after reset.
module two_key_record_sorter #(
  parameter int unsigned MAX_RECORDS = tkrs_pkg::MaxRecords,
  parameter int unsigned NAME_BYTES  = tkrs_pkg::NameBytes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // id, name_w0..w4, program, score_bits, zero fill
  input  logic [tkrs_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  logic                          s_axis_tlast_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // id, name_w0..w4, program, score_bits, zero fill
  output logic [tkrs_pkg::InDataW-1:0]  m_axis_tdata_o,
  output logic                          m_axis_tlast_o,
  // overflow
  output logic                          m_axis_tuser_o
);
  import tkrs_pkg::*;
  `include "two_key_record_sorter_macros.svh"

  localparam int unsigned AW = $clog2(MAX_RECORDS);
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]    state_q, state_d;
  logic          by_name_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic          last_q, last_d;
  logic [CW-1:0] pos_q, pos_d;   // walk position: next slot to examine is pos-1
  logic [CW-1:0] rd_q, rd_d;     // read-out slot
  key_t          new_key_q;
  logic [AW-1:0] new_idx_q;

  rec_t          rec_mem [MAX_RECORDS];
  key_t          key_mem [MAX_RECORDS];
  logic [AW-1:0] ord_mem [MAX_RECORDS];
  key_t          key_rd_q;
  logic [AW-1:0] ord_rd_q;
  rec_t          rec_rd_q;

  logic          in_fire, goes_first;
  rec_t          in_rec;
  logic          k_we, rec_we;
  logic [AW-1:0] k_wa, k_ra;
  key_t          k_wd;
  logic [AW-1:0] o_wd;

  assign in_rec.id    = s_axis_tdata_i[IdW-1:0];
  assign in_rec.name  = name_mask({s_axis_tdata_i[IdW+:64],
      s_axis_tdata_i[IdW+64+:64], s_axis_tdata_i[IdW+128+:64],
      s_axis_tdata_i[IdW+192+:64], s_axis_tdata_i[IdW+256+:64]}, NAME_BYTES);
  assign in_rec.prog  = s_axis_tdata_i[IdW+NameW+:ProgW];
  assign in_rec.score = s_axis_tdata_i[IdW+NameW+ProgW+:ScoreW];

  // Output skid: two slots
  logic          ob_v_q [2];
  rec_t          ob_r_q [2];
  logic          ob_l_q [2], ob_o_q [2];
  logic          ob_rp_q, ob_wp_q;
  logic          pend_q, pend_d;   // read issued last cycle, its order index lands now
  logic          pend_last_q, pend_last_d;
  logic          issue_q, issue_last_q;
  logic [1:0]    ob_cnt;
  logic          out_fire;

  assign ob_cnt = {1'b0, ob_v_q[0]} + {1'b0, ob_v_q[1]};
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  tkrs_cmp u_cmp (
    .by_name_i (by_name_q),
    .a_i       (new_key_q),
    .b_i       (key_rd_q),
    .before_o  (goes_first)
  );

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; ovf_d = ovf_q; last_d = last_q;
    pos_d = pos_q; rd_d = rd_q; pend_d = 1'b0; pend_last_d = pend_last_q;
    k_we = 1'b0; rec_we = 1'b0; k_wa = '0; k_ra = '0; k_wd = new_key_q;
    o_wd = new_idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          last_d = s_axis_tlast_i;
          if (cnt_q < CW'(MAX_RECORDS)) begin
            rec_we = 1'b1;
            pos_d  = cnt_q;
            cnt_d  = cnt_q + 1'b1;
            state_d = S_WALK;
            k_ra   = (cnt_q == '0) ? '0 : AW'(cnt_q - 1'b1);
          end else begin
            ovf_d = 1'b1;
            if (s_axis_tlast_i) begin
              state_d = S_OUT; rd_d = '0;
            end
          end
        end
      end
      S_WALK: begin
        // key_rd_q holds slot pos-1 when pos > 0
        k_we = 1'b1;
        if (pos_q != '0 && goes_first) begin
          k_wa = AW'(pos_q);
          k_wd = key_rd_q;
          o_wd = ord_rd_q;
          pos_d = pos_q - 1'b1;
          k_ra = (pos_q == CW'(1)) ? '0 : AW'(pos_q - 2'd2);
        end else begin
          k_wa = AW'(pos_q);
          state_d = last_q ? S_OUT : S_IDLE;
          rd_d = '0;
        end
      end
      S_OUT: begin
        k_ra = AW'(rd_q);
        // Issue only while the skid can hold everything in flight
        if (rd_q < cnt_q && ({1'b0, ob_cnt} + {2'b0, pend_q} + {2'b0, issue_q}
            - {2'b0, out_fire}) < 3'd2) begin
          pend_d = 1'b1;
          pend_last_d = (rd_q + 1'b1 == cnt_q);
          rd_d = rd_q + 1'b1;
        end
        if (rd_q == cnt_q && !pend_q && !issue_q && ob_cnt == 2'd0) begin
          state_d = S_IDLE; cnt_d = '0; ovf_d = 1'b0;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Memories: key/order read for walk and output, record read via order for output
  always_ff @(posedge clk_i) begin
    if (rec_we) rec_mem[AW'(cnt_q)] <= in_rec;
    if (k_we) begin
      key_mem[k_wa] <= k_wd;
      ord_mem[k_wa] <= o_wd;
    end
    key_rd_q <= key_mem[k_ra];
    ord_rd_q <= ord_mem[k_ra];
  end

  // Second stage of output read: record from the order index
  always_ff @(posedge clk_i) begin
    rec_rd_q <= rec_mem[ord_rd_q];
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      new_key_q <= '{name: name_canon(in_rec.name), id: in_rec.id};
      new_idx_q <= AW'(cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; by_name_q <= 1'b0; cnt_q <= '0; ovf_q <= 1'b0;
      last_q <= 1'b0; pos_q <= '0; rd_q <= '0; pend_q <= 1'b0;
      pend_last_q <= 1'b0; issue_q <= 1'b0; issue_last_q <= 1'b0;
      ob_v_q[0] <= 1'b0; ob_v_q[1] <= 1'b0; ob_rp_q <= 1'b0; ob_wp_q <= 1'b0;
    end else begin
      if (cfg_we_i) by_name_q <= cfg_wdata_i;
      state_q <= state_d; cnt_q <= cnt_d; ovf_q <= ovf_d; last_q <= last_d;
      pos_q <= pos_d; rd_q <= rd_d;
      pend_q <= pend_d; pend_last_q <= pend_last_d;
      issue_q <= pend_q; issue_last_q <= pend_last_q;
      if (out_fire) begin
        ob_v_q[ob_rp_q] <= 1'b0;
        ob_rp_q <= ~ob_rp_q;
      end
      if (issue_q) begin
        ob_v_q[ob_wp_q] <= 1'b1;
        ob_wp_q <= ~ob_wp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_q) begin
      ob_r_q[ob_wp_q] <= rec_rd_q;
      ob_l_q[ob_wp_q] <= issue_last_q;
      ob_o_q[ob_wp_q] <= ovf_q;
    end
  end

  // Output read runs two stages deep, so the state counts both in flight.
  logic pend2;
  assign pend2 = issue_q;

  assign m_axis_tvalid_o = ob_v_q[ob_rp_q];
  assign m_axis_tdata_o  = {{(InDataW-RecW){1'b0}}, ob_r_q[ob_rp_q].score,
      ob_r_q[ob_rp_q].prog,
      ob_r_q[ob_rp_q].name[63:0], ob_r_q[ob_rp_q].name[127:64],
      ob_r_q[ob_rp_q].name[191:128], ob_r_q[ob_rp_q].name[255:192],
      ob_r_q[ob_rp_q].name[319:256], ob_r_q[ob_rp_q].id};
  assign m_axis_tlast_o  = ob_l_q[ob_rp_q];
  assign m_axis_tuser_o  = ob_o_q[ob_rp_q];

  `TKRS_ASSERT(a_no_in_busy, clk_i, rst_ni, !(in_fire && state_q != S_IDLE), "accept while busy")
  `TKRS_ASSERT(a_cnt_rng, clk_i, rst_ni, cnt_q <= CW'(MAX_RECORDS), "count beyond capacity")
  `TKRS_ASSERT_NEXT(a_skid, clk_i, rst_ni, issue_q && ob_cnt == 2'd2 && !out_fire, 1'b0, "skid overrun")
  `TKRS_ASSERT(a_pend_cap, clk_i, rst_ni, !(pend2 && pend_q && ob_cnt != 2'd0 && !out_fire), "too many reads in flight")
endmodule

// File: hdl/tkrs_cmp.sv
`timescale 1ns / 1ps
module tkrs_cmp (
  input  logic          by_name_i,
  input  tkrs_pkg::key_t a_i,
  input  tkrs_pkg::key_t b_i,
  output logic          before_o
);
  import tkrs_pkg::*;
  logic name_lt, name_eq;
  // Canonical names are stored, so a wide unsigned compare matches strcmp.
  assign name_lt  = a_i.name < b_i.name;
  assign name_eq  = a_i.name == b_i.name;
  assign before_o = (by_name_i && !name_eq) ? name_lt : (a_i.id < b_i.id);
endmodule
